// ===== src/boxcar_moving_average_top_assert.svh =====
// Assertion macros shared by the boxcar moving-average modules.
`ifndef BOXCAR_MOVING_AVERAGE_TOP_ASSERT_SVH
`define BOXCAR_MOVING_AVERAGE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
// The module must have signals named clk and arst_n.
`define BMA_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMA_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bma_pkg.sv =====
// Shared constants and types of the boxcar moving-average filter.
package bma_pkg;

	localparam int MAX_WINDOW_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int WINDOW_RESET     = 8;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV
	} bma_state_t;

endpackage

// ===== src/bma_cfg_if.sv =====
// Configuration write channel carrying the window length.
interface bma_cfg_if #(
	parameter int WIN_W = 7
);
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_length;

	modport source (output valid, output window_length, input ready);
	modport sink   (input valid, input window_length, output ready);
endinterface

// ===== src/bma_in_if.sv =====
// Input channel carrying a command and one sample.
interface bma_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink   (input valid, input command, input sample, output ready);
endinterface

// ===== src/bma_out_if.sv =====
// Result channel carrying one average.
interface bma_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;

	modport source (output valid, output average, input ready);
	modport sink   (input valid, input average, output ready);
endinterface

// ===== src/bma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/bma_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module bma_div
	import bma_pkg::*;
#(
	parameter int DIVIDEND_W = 22,
	parameter int DIVISOR_W  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	`include "boxcar_moving_average_top_assert.svh"

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W+1:0]  diff;
	logic                  fits;

	// The partial remainder stays below the divisor, so its shifted form
	// needs one extra bit and the trial subtraction one more for the borrow.
	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		fits   = !diff[DIVISOR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	`BMA_CHECK_NEXT(a_div_starts, start, busy_q, "divider did not start")
	`BMA_CHECK(a_div_count_live, busy_q, cnt_q != '0, "divider busy with no bits left")
	`BMA_CHECK(a_div_idle_empty, !busy_q, cnt_q == '0, "idle divider holds a bit count")

endmodule

// ===== src/boxcar_moving_average_top.sv =====
// Top level of the boxcar moving-average filter.
//
// The filter takes signed samples on sample_ch and returns, for every sample
// command, the mean of the most recent window_length samples on result_ch,
// truncated toward zero and in the same format as the input. Until the window
// has filled, the mean is taken over the samples received so far. A clear
// command empties the history and gives no result. Writing window_length on
// cfg_ch (legal values 1 to MAX_WINDOW; others are dropped) also clears the
// history. The past samples live in one RAM with a registered read port; the
// running sum, fill count and write position are registers. A sample passes
// through these steps: the RAM read happens at the transfer edge, then the
// sum update and write-back, then the restoring divider works out the
// quotient bit by bit, and then the output register is loaded. The next
// sample can be transferred in the cycle in which the result appears, so the
// block takes no new sample before the last one is through; a result that
// the sink does not take holds the next one back in the divider. A clear
// command is taken only while idle. The block works on one sample at a
// time, but it takes the next sample while a finished result still waits
// in the output register. No clearing pass is needed after reset.
module boxcar_moving_average_top
	import bma_pkg::*;
#(
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bma_cfg_if.sink    cfg_ch,
	bma_in_if.sink     sample_ch,
	bma_out_if.source  result_ch
);

	`include "boxcar_moving_average_top_assert.svh"

	// Widths of the write position, the fill count and the running sum.
	localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
	localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	bma_state_t state_q, state_d;

	logic [CNT_W-1:0]        window_q;
	logic [CNT_W-1:0]        count_q;
	logic [PTR_W-1:0]        pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] avg_q;

	logic                    cfg_acc;
	logic                    cfg_ok;
	logic                    in_acc;
	logic                    rd_en;
	logic [SAMPLE_WIDTH-1:0] old_sample;
	logic                    full;
	logic signed [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0]        sum_mag;
	logic [CNT_W-1:0]        count_d;
	logic [PTR_W-1:0]        pos_d;
	logic                    upd;
	logic                    div_busy;
	logic [SUM_W-1:0]        div_quo;
	logic [SUM_W-1:0]        quo_signed;
	logic                    out_free;
	logic                    load_out;

	// Configuration is always taken; out-of-range lengths are dropped.
	assign cfg_ch.ready = 1'b1;
	assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
	assign cfg_ok       = (cfg_ch.window_length != '0) &&
	                      (cfg_ch.window_length <= CNT_W'(MAX_WINDOW));

	assign in_acc = sample_ch.valid && sample_ch.ready;
	assign rd_en  = in_acc && (sample_ch.command == CMD_SAMPLE);

	// Sum update in the cycle after the read: drop the oldest sample once the
	// window is full, otherwise grow the fill count. The magnitude of the new
	// sum goes to the divider and its sign is kept for the result.
	always_comb begin
		full    = (count_q >= window_q);
		sum_d   = sum_q + SUM_W'(signed'(sample_s1))
		          - (full ? SUM_W'(signed'(old_sample)) : '0);
		sum_mag = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
		count_d = full ? count_q : count_q + CNT_W'(1);
		pos_d   = ((CNT_W'(pos_q) + CNT_W'(1)) == window_q) ? '0 : pos_q + PTR_W'(1);
	end

	assign out_free   = !out_valid_q || result_ch.ready;
	assign quo_signed = neg_q ? (~div_quo + SUM_W'(1)) : div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		sample_ch.ready   = 1'b0;
		upd               = 1'b0;
		load_out          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ch.ready = 1'b1;
				if (rd_en) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				upd     = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy && out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Window register and the history bookkeeping. A clear command and a
	// legal window write both empty the history; RAM contents are left as
	// they are, since an entry's old value is used only after it was rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CNT_W'(WIN_RST);
			count_q  <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (cfg_acc && cfg_ok) begin
				window_q <= cfg_ch.window_length;
				count_q  <= '0;
				pos_q    <= '0;
				sum_q    <= '0;
			end else if (in_acc && (sample_ch.command == CMD_CLEAR)) begin
				count_q <= '0;
				pos_q   <= '0;
				sum_q   <= '0;
			end else if (upd) begin
				count_q <= count_d;
				pos_q   <= pos_d;
				sum_q   <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sample_s1 <= sample_ch.sample;
		end
		if (upd) begin
			neg_q <= sum_d[SUM_W-1];
		end
		if (load_out) begin
			avg_q <= quo_signed[SAMPLE_WIDTH-1:0];
		end
	end

	// Output register: a result waits here until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid   = out_valid_q;
	assign result_ch.average = avg_q;

	// Sample history: read at the accepted sample, written back in the cycle after.
	bma_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_WINDOW)
	) u_history (
		.clk     (clk),
		.wr_en   (upd),
		.wr_addr (pos_q),
		.wr_data (sample_s1),
		.rd_en   (rd_en),
		.rd_addr (pos_q),
		.rd_data (old_sample)
	);

	// The fill count is never zero when a division starts.
	bma_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd),
		.dividend (sum_mag),
		.divisor  (count_d),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	`BMA_CHECK(a_fill_in_window, 1'b1, count_q <= window_q, "fill count beyond window")
	`BMA_CHECK(a_pos_in_window, 1'b1, CNT_W'(pos_q) < window_q, "write position beyond window")
	`BMA_CHECK_NEXT(a_result_loaded, load_out, out_valid_q && state_q == ST_IDLE, "no result")

endmodule

// ===== verif/bma_average_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the filter's averages and compares them with the result channel.
module bma_average_checker
	import bma_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [$clog2(MAX_WINDOW_DEF):0] cfg_window,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           in_command,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] in_sample,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] out_average,
	output int                             mismatch_count,
	output int                             pending_averages
);

	localparam int SW    = SAMPLE_WIDTH_DEF;
	localparam int POS_W = $clog2(MAX_WINDOW_DEF);
	localparam int WIN_W = POS_W + 1;
	localparam int SUM_W = SW + POS_W;

	logic [WIN_W-1:0]        window_len;
	logic signed [SW-1:0]    ring [MAX_WINDOW_DEF];
	logic [POS_W-1:0]        wr_pos;
	logic [WIN_W-1:0]        filled;
	logic signed [SUM_W-1:0] running_total;
	logic signed [SW-1:0]    expected_averages [$];

	function automatic void clear_history();
		wr_pos        = '0;
		filled        = '0;
		running_total = '0;
	endfunction

	// Stores one sample in the ring and returns the mean of the window after it.
	function automatic logic signed [SW-1:0] average_after(input logic signed [SW-1:0] x);
		int unsigned pos;
		int          quotient;
		pos = wr_pos;
		if (filled >= window_len) begin
			running_total = running_total - ring[pos];
		end else begin
			filled = filled + 1'b1;
		end
		ring[pos]     = x;
		running_total = running_total + x;
		wr_pos        = POS_W'((pos + 1) % window_len);
		// Integer division in SystemVerilog truncates toward zero.
		quotient = int'(running_total) / int'(filled);
		return SW'(quotient);
	endfunction

	function automatic void flag_mismatch(input string what);
		if (mismatch_count < 10) begin
			$display("%0t: average mismatch: %s", $time, what);
		end
		mismatch_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SW-1:0] want;
		if (!arst_n) begin
			window_len = WIN_W'(WINDOW_RESET);
			clear_history();
			expected_averages.delete();
			mismatch_count   = 0;
			pending_averages = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					flag_mismatch($sformatf("expected none, got %0d", out_average));
				end else begin
					want = expected_averages.pop_front();
					if (out_average !== want) begin
						flag_mismatch($sformatf("expected %0d, got %0d", want, out_average));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_window >= 1 && cfg_window <= MAX_WINDOW_DEF) begin
					window_len = cfg_window;
					clear_history();
				end
			end
			if (in_valid && in_ready) begin
				if (in_command == CMD_CLEAR) begin
					clear_history();
				end else begin
					expected_averages.push_back(average_after(in_sample));
				end
			end
			pending_averages = expected_averages.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top of the boxcar moving-average filter: stimulus, idling and verdict.
module tb_top;
	import bma_pkg::*;

	localparam int SW            = SAMPLE_WIDTH_DEF;
	localparam int WIN_W         = $clog2(MAX_WINDOW_DEF) + 1;
	localparam int ITEM_TARGET   = 1750;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// Extra wait at the end of a drain; it covers both a sample and a clear.
	localparam int SETTLE_CYCLES = 40;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	// How the samples of one random phase are drawn.
	typedef enum int {
		MIX_FULL_RANGE,
		MIX_NEAR_ZERO,
		MIX_ALL_MAX,
		MIX_ALL_MIN,
		MIX_EXTREMES
	} sample_mix_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatch_count;
	int   pending_averages;
	int   cycle_count   = 0;
	int   items_sent    = 0;
	bit   in_gaps_on    = 1'b1;
	bit   out_stalls_on = 1'b1;

	bma_cfg_if #(.WIN_W(WIN_W))       cfg_ch ();
	bma_in_if  #(.SAMPLE_WIDTH(SW))   sample_ch ();
	bma_out_if #(.SAMPLE_WIDTH(SW))   result_ch ();

	boxcar_moving_average_top #(
		.MAX_WINDOW   (MAX_WINDOW_DEF),
		.SAMPLE_WIDTH (SW)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_ch    (cfg_ch),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// The checker only watches; it keeps its own copy of the filter state.
	bma_average_checker u_average_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_ch.valid),
		.cfg_ready        (cfg_ch.ready),
		.cfg_window       (cfg_ch.window_length),
		.in_valid         (sample_ch.valid),
		.in_ready         (sample_ch.ready),
		.in_command       (sample_ch.command),
		.in_sample        (sample_ch.sample),
		.out_valid        (result_ch.valid),
		.out_ready        (result_ch.ready),
		.out_average      (result_ch.average),
		.mismatch_count   (mismatch_count),
		.pending_averages (pending_averages)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A hung handshake must not keep the run alive forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Result side back-pressure. Ready is held for a random number of cycles:
	// mostly short high and low stretches, now and then a long stall, and no
	// stalls at all while out_stalls_on is cleared.
	initial begin
		int hold;
		int pick;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!out_stalls_on) begin
				result_ch.ready <= 1'b1;
			end else begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					result_ch.ready <= 1'b1;
					hold = $urandom_range(0, 7);
				end else if (pick < 95) begin
					result_ch.ready <= 1'b0;
					hold = $urandom_range(0, 2);
				end else begin
					result_ch.ready <= 1'b0;
					hold = $urandom_range(15, 60);
				end
			end
		end
	end

	// Idle cycles in front of one input transfer: usually none or a few,
	// sometimes a long pause that lets the block run empty.
	function automatic int pick_gap();
		int pick;
		if (!in_gaps_on) begin
			return 0;
		end
		pick = $urandom_range(99);
		if (pick < 60) begin
			return 0;
		end else if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [SW-1:0] pick_sample(input sample_mix_t mix);
		int offset;
		case (mix)
			MIX_NEAR_ZERO: begin
				offset = int'($urandom_range(0, 10)) - 5;
				return SW'(offset);
			end
			MIX_ALL_MAX:  return SAMPLE_MAX;
			MIX_ALL_MIN:  return SAMPLE_MIN;
			MIX_EXTREMES: return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
			default:      return SW'($urandom);
		endcase
	endfunction

	// Moves one item into the block. Called at a falling edge and returns at the
	// falling edge after the transfer, with valid still high, so that a
	// back-to-back item keeps valid up without a glitch.
	task automatic send_item(input logic cmd, input logic signed [SW-1:0] smp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.command <= cmd;
		sample_ch.sample  <= smp;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Stops the input stream and waits until every average has come out. A
	// trailing clear gives no result, so a further SETTLE_CYCLES wait follows for it.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_averages != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The window register is only written while the block is idle.
	task automatic write_window(input logic [WIN_W-1:0] value);
		drain();
		cfg_ch.valid         <= 1'b1;
		cfg_ch.window_length <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int               phase;
		int               span;
		int               bad_at;
		int               window;
		logic [WIN_W-1:0] bad_value;
		sample_mix_t      mix;

		sample_ch.valid      = 1'b0;
		sample_ch.command    = CMD_SAMPLE;
		sample_ch.sample     = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.window_length = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the reset window of eight: both extremes, zero and
		// the smallest magnitudes, then clears on a partly filled and on an
		// empty history.
		send_item(CMD_SAMPLE, SAMPLE_MAX);
		send_item(CMD_SAMPLE, SAMPLE_MIN);
		send_item(CMD_SAMPLE, SW'(0));
		send_item(CMD_SAMPLE, SW'(-1));
		send_item(CMD_SAMPLE, SW'(1));
		send_item(CMD_CLEAR, SAMPLE_MAX);
		send_item(CMD_CLEAR, SW'(0));
		// -3, then -1 / 2 and -5 / 3: negative quotients must truncate toward
		// zero, not toward minus infinity.
		send_item(CMD_SAMPLE, SW'(-3));
		send_item(CMD_SAMPLE, SW'(2));
		send_item(CMD_SAMPLE, SW'(-4));
		// Fill the window and run past it so the oldest samples drop out.
		repeat (9) send_item(CMD_SAMPLE, SAMPLE_MIN);
		repeat (3) send_item(CMD_SAMPLE, SAMPLE_MAX);

		// Random phases. Each one sets a window, possibly drops in an illegal
		// write that must leave the history alone, and then streams samples
		// with the odd clear. The first phases pin down the extremes: a window
		// of one, and a full window of 64 at the lowest and highest sums.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0:       begin window = 1;  mix = MIX_FULL_RANGE; end
				1:       begin window = 64; mix = MIX_ALL_MIN;    end
				2:       begin window = 64; mix = MIX_ALL_MAX;    end
				3:       begin window = 2;  mix = MIX_NEAR_ZERO;  end
				4:       begin window = 63; mix = MIX_EXTREMES;   end
				default: begin
					window = ($urandom_range(4) == 0) ?
						(($urandom_range(1) != 0) ? 64 : 1) : $urandom_range(1, 64);
					mix = sample_mix_t'($urandom_range(MIX_EXTREMES));
				end
			endcase
			in_gaps_on    = ($urandom_range(4) != 0);
			out_stalls_on = ($urandom_range(4) != 0);
			write_window(WIN_W'(window));

			span   = window + $urandom_range(20, 120);
			bad_at = -1;
			if (phase < 2 || $urandom_range(2) == 0) begin
				bad_at = $urandom_range(1, span - 1);
			end
			if (phase == 0) begin
				bad_value = '0;
			end else if (phase == 1) begin
				bad_value = '1;
			end else begin
				bad_value = ($urandom_range(1) != 0) ? '0 :
					WIN_W'($urandom_range(MAX_WINDOW_DEF + 1, (1 << WIN_W) - 1));
			end

			for (int i = 0; i < span; i++) begin
				if (i == bad_at) begin
					write_window(bad_value);
				end
				if ($urandom_range(99) < 4) begin
					send_item(CMD_CLEAR, SW'($urandom));
				end else begin
					send_item(CMD_SAMPLE, pick_sample(mix));
				end
			end
			phase++;
		end

		drain();
		if (mismatch_count == 0 && pending_averages == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/bma_pkg.sv
src/bma_cfg_if.sv
src/bma_in_if.sv
src/bma_out_if.sv
src/bma_ram.sv
src/bma_div.sv
src/boxcar_moving_average_top.sv
verif/bma_average_checker.sv
verif/tb_top.sv
